// ===== rtl/rkq_pkg.sv =====
// shared types, constants and lookup functions for the romaji kana key queue
// no dependencies
`default_nettype none

package rkq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [7:0] code_t;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  localparam logic [2:0] VCOL_A    = 3'd0;
  localparam logic [2:0] VCOL_I    = 3'd1;
  localparam logic [2:0] VCOL_U    = 3'd2;
  localparam logic [2:0] VCOL_E    = 3'd3;
  localparam logic [2:0] VCOL_O    = 3'd4;
  localparam logic [2:0] VCOL_NONE = 3'd5;

  localparam code_t CH_A = 8'h41;
  localparam code_t CH_B = 8'h42;
  localparam code_t CH_D = 8'h44;
  localparam code_t CH_E = 8'h45;
  localparam code_t CH_F = 8'h46;
  localparam code_t CH_G = 8'h47;
  localparam code_t CH_H = 8'h48;
  localparam code_t CH_I = 8'h49;
  localparam code_t CH_J = 8'h4A;
  localparam code_t CH_K = 8'h4B;
  localparam code_t CH_M = 8'h4D;
  localparam code_t CH_N = 8'h4E;
  localparam code_t CH_O = 8'h4F;
  localparam code_t CH_P = 8'h50;
  localparam code_t CH_R = 8'h52;
  localparam code_t CH_S = 8'h53;
  localparam code_t CH_T = 8'h54;
  localparam code_t CH_U = 8'h55;
  localparam code_t CH_W = 8'h57;
  localparam code_t CH_Y = 8'h59;
  localparam code_t CH_Z = 8'h5A;

  localparam code_t KANA_VOWEL = 8'd96;
  localparam code_t KANA_YA    = 8'd131;
  localparam code_t KANA_YU    = 8'd132;
  localparam code_t KANA_YO    = 8'd133;
  localparam code_t KANA_WA    = 8'd139;
  localparam code_t KANA_NN    = 8'd140;
  localparam code_t KANA_WO    = 8'd141;

  typedef struct packed {
    code_t code;
    code_t pending;
  } xlate_t;

  typedef struct packed {
    logic step;
    logic push;
    logic pop;
  } fifo_ctrl_t;

  function automatic logic [2:0] vowel_col(input code_t c);
    logic [2:0] col;
    case (c)
      CH_A:    col = VCOL_A;
      CH_I:    col = VCOL_I;
      CH_U:    col = VCOL_U;
      CH_E:    col = VCOL_E;
      CH_O:    col = VCOL_O;
      default: col = VCOL_NONE;
    endcase
    return col;
  endfunction

  function automatic logic is_consonant(input code_t c);
    logic hit;
    case (c)
      CH_K, CH_S, CH_T, CH_N, CH_H, CH_M, CH_Y, CH_R,
      CH_W, CH_G, CH_Z, CH_D, CH_B, CH_P, CH_J, CH_F: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // consonant plus vowel column, zero for gaps
  function automatic code_t row_code(input code_t c, input logic [2:0] v);
    code_t base;
    code_t res;
    base = '0;
    res  = '0;
    case (c)
      CH_K:    base = 8'd101;
      CH_S:    base = 8'd106;
      CH_T:    base = 8'd111;
      CH_N:    base = 8'd116;
      CH_H:    base = 8'd121;
      CH_M:    base = 8'd126;
      CH_R:    base = 8'd134;
      CH_G:    base = 8'd151;
      CH_Z:    base = 8'd156;
      CH_D:    base = 8'd161;
      CH_B:    base = 8'd166;
      CH_P:    base = 8'd171;
      default: base = '0;
    endcase
    if (c == CH_Y) begin
      case (v)
        VCOL_A:  res = KANA_YA;
        VCOL_U:  res = KANA_YU;
        VCOL_O:  res = KANA_YO;
        default: res = '0;
      endcase
    end else if (c == CH_W) begin
      case (v)
        VCOL_A:  res = KANA_WA;
        VCOL_O:  res = KANA_WO;
        default: res = '0;
      endcase
    end else if (base != '0) begin
      res = base + {5'd0, v};
    end
    return res;
  endfunction

  function automatic ptr_t next_ptr(input ptr_t p);
    ptr_t n;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/romaji_kana_key_queue.sv =====
// the input register takes each transfer; translation and one fifo access then load
// the result register on a step, and the output transfer reads the result register
// throughput: one item per cycle while out_ready stays high
// rate is set by the single pass from the input register through translation
// and one fifo access into the result register
// reset: kana mode off, nothing pending, fifo empty, toggle_key 0
`default_nettype none

module romaji_kana_key_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [7:0]          cfg_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                action,
  input  wire [7:0]          key_code,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               key_valid,
  output logic [7:0]         key_out,
  output logic               kana_on
);
  import rkq_pkg::*;

  code_t      toggle_key;
  logic       kana_mode;
  logic       kana_mode_next;
  code_t      pending_consonant;
  code_t      pending_consonant_next;
  logic       s1_valid;
  logic       s1_action;
  code_t      s1_code;
  logic       step;
  logic       is_push;
  logic       is_toggle;
  logic       push_req;
  logic       pop_req;
  code_t      push_code;
  xlate_t     xl;
  fifo_ctrl_t fctrl;
  logic       fifo_empty;
  logic       fifo_full;

  assign cfg_ready = 1'b1;
  assign step      = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      toggle_key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      toggle_key <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_code   <= key_code;
    end
  end

  rkq_xlate u_xlate (
    .code    (s1_code),
    .pending (pending_consonant),
    .result  (xl)
  );

  always_comb begin
    is_push                = (s1_action == ACT_PUSH);
    is_toggle              = is_push && (s1_code == toggle_key);
    kana_mode_next         = kana_mode;
    pending_consonant_next = pending_consonant;
    push_code              = kana_mode ? xl.code : s1_code;
    push_req               = 1'b0;
    if (is_toggle) begin
      kana_mode_next         = !kana_mode;
      pending_consonant_next = '0;
    end else if (is_push) begin
      push_req = !kana_mode || (xl.code != '0);
      if (kana_mode) begin
        pending_consonant_next = xl.pending;
      end
    end
    pop_req     = !is_push && !fifo_empty;
    fctrl.step  = step;
    fctrl.push  = step && push_req;
    fctrl.pop   = step && pop_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kana_mode         <= 1'b0;
      pending_consonant <= '0;
    end else if (step) begin
      kana_mode         <= kana_mode_next;
      pending_consonant <= pending_consonant_next;
    end
  end

  rkq_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (fctrl),
    .wr_data (push_code),
    .rd_data (key_out),
    .empty   (fifo_empty),
    .full    (fifo_full)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      key_valid <= pop_req;
      kana_on   <= kana_mode_next;
    end
  end

`ifndef SYNTHESIS
  a_fifo_sane: assert property (@(posedge clk) disable iff (rst)
    !(fifo_full && fifo_empty))
    else $error("fifo reports full and empty together");

  a_step_loads: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("result register not loaded after transfer");

  a_no_key_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !key_valid) |-> (key_out == '0))
    else $error("key_out nonzero without a popped key");

  a_pending_kana: assert property (@(posedge clk) disable iff (rst)
    (pending_consonant != '0) |-> kana_mode)
    else $error("pending consonant held outside kana mode");
`endif

endmodule

`default_nettype wire

// ===== rtl/rkq_xlate.sv =====
// romaji to kana translation of one key against the pending consonant
// depends on rkq_pkg
`default_nettype none

module rkq_xlate (
  input  wire rkq_pkg::code_t  code,
  input  wire rkq_pkg::code_t  pending,
  output rkq_pkg::xlate_t      result
);
  import rkq_pkg::*;

  logic [2:0] v;
  code_t      c;

  always_comb begin
    v = vowel_col(code);
    c = pending;
    if (pending == CH_J) begin
      c = CH_Z;
    end else if (pending == CH_F) begin
      c = CH_H;
    end
    result.code    = code;
    result.pending = '0;
    if (pending != '0 && c == CH_N && code == CH_N) begin
      result.code = KANA_NN;
    end else if (pending != '0 && v != VCOL_NONE) begin
      result.code = row_code(c, v);
    end else if (v != VCOL_NONE) begin
      result.code = KANA_VOWEL + {5'd0, v};
    end else if (is_consonant(code)) begin
      result.code    = '0;
      result.pending = code;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rkq_fifo.sv =====
// ring buffer of key codes that keeps one slot empty, registered read data
// depends on rkq_pkg
`default_nettype none

module rkq_fifo (
  input  wire                     clk,
  input  wire                     rst,
  input  wire rkq_pkg::fifo_ctrl_t ctrl,
  input  wire rkq_pkg::code_t     wr_data,
  output rkq_pkg::code_t          rd_data,
  output logic                    empty,
  output logic                    full
);
  import rkq_pkg::*;

  code_t store [QUEUE_DEPTH];
  ptr_t  rd_ptr;
  ptr_t  wr_ptr;
  logic  push_ok;
  logic  pop_ok;

  assign empty   = (rd_ptr == wr_ptr);
  assign full    = (next_ptr(wr_ptr) == rd_ptr);
  assign push_ok = ctrl.push && !full;
  assign pop_ok  = ctrl.pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= next_ptr(wr_ptr);
      end
      if (pop_ok) begin
        rd_ptr <= next_ptr(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      rd_data <= pop_ok ? store[rd_ptr] : '0;
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for the romaji kana key queue: drives pushes, pops and toggle_key writes,
// predicts every result from its own model of the converter and fifo, checks field by field
// depends on rtl/rkq_pkg.sv and rtl/romaji_kana_key_queue.sv
`default_nettype none

module testbench;
  import rkq_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 260;
  localparam int CALM_JOBS     = 150;

  typedef struct {
    bit      is_cfg;
    action_t act;
    code_t   code;
  } key_job_t;

  typedef struct packed {
    logic  key_valid;
    code_t key_out;
    logic  kana_on;
  } key_result_t;

  logic    clk;
  logic    rst = 1'b1;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  code_t   cfg_data = '0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  action_t action_d = ACT_PUSH;
  code_t   key_code = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  logic    key_valid;
  code_t   key_out;
  logic    kana_on;

  key_job_t    key_jobs[$];
  key_result_t kana_results[$];

  // model state
  code_t toggle_m;
  logic  kana_m;
  code_t pend_m;
  code_t store_m [QUEUE_DEPTH];
  ptr_t  rd_m;
  ptr_t  wr_m;

  logic drained = 1'b1;
  logic calm = 1'b0;
  logic hold_off = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   results_seen = 0;
  int   errors = 0;
  int   tx_gap = 0;
  int   tx_odds = 4;
  int   settle = 0;
  int   rx_gap = 0;
  int   rx_odds = 4;

  romaji_kana_key_queue uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action_d),
    .key_code  (key_code),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .key_valid (key_valid),
    .key_out   (key_out),
    .kana_on   (kana_on)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic key_result_t apply_keystroke(action_t act, code_t c);
    key_result_t r;
    code_t       t;
    code_t       held;
    logic        keep;
    ptr_t        nxt;
    int          col;
    r    = '0;
    t    = c;
    keep = 1'b0;
    if (act == ACT_PUSH) begin
      if (c == toggle_m) begin
        kana_m = ~kana_m;
        pend_m = '0;
      end else if (!kana_m) begin
        keep = 1'b1;
      end else begin
        case (c)
          CH_A:    col = 0;
          CH_I:    col = 1;
          CH_U:    col = 2;
          CH_E:    col = 3;
          CH_O:    col = 4;
          default: col = 5;
        endcase
        held = pend_m;
        if (held == CH_J) begin
          held = CH_Z;
        end else if (held == CH_F) begin
          held = CH_H;
        end
        pend_m = '0;
        if (held != '0 && held == CH_N && c == CH_N) begin
          t = KANA_NN;
        end else if (held != '0 && col < 5) begin
          case (held)
            CH_Y:    t = (col == 0) ? KANA_YA : (col == 2) ? KANA_YU :
                         (col == 4) ? KANA_YO : code_t'(0);
            CH_W:    t = (col == 0) ? KANA_WA : (col == 4) ? KANA_WO : code_t'(0);
            CH_K:    t = 8'd101 + code_t'(col);
            CH_S:    t = 8'd106 + code_t'(col);
            CH_T:    t = 8'd111 + code_t'(col);
            CH_N:    t = 8'd116 + code_t'(col);
            CH_H:    t = 8'd121 + code_t'(col);
            CH_M:    t = 8'd126 + code_t'(col);
            CH_R:    t = 8'd134 + code_t'(col);
            CH_G:    t = 8'd151 + code_t'(col);
            CH_Z:    t = 8'd156 + code_t'(col);
            CH_D:    t = 8'd161 + code_t'(col);
            CH_B:    t = 8'd166 + code_t'(col);
            CH_P:    t = 8'd171 + code_t'(col);
            default: t = '0;
          endcase
        end else if (col < 5) begin
          t = KANA_VOWEL + code_t'(col);
        end else begin
          case (c)
            CH_K, CH_S, CH_T, CH_N, CH_H, CH_M, CH_Y, CH_R,
            CH_W, CH_G, CH_Z, CH_D, CH_B, CH_P, CH_J, CH_F: begin
              pend_m = c;
              t = '0;
            end
            default: t = c;
          endcase
        end
        keep = (t != '0);
      end
      if (keep) begin
        nxt = ptr_t'((int'(wr_m) + 1) % QUEUE_DEPTH);
        if (nxt != rd_m) begin
          store_m[wr_m] = t;
          wr_m = nxt;
        end
      end
    end else if (rd_m != wr_m) begin
      r.key_valid = 1'b1;
      r.key_out   = store_m[rd_m];
      rd_m = ptr_t'((int'(rd_m) + 1) % QUEUE_DEPTH);
    end
    r.kana_on = kana_m;
    return r;
  endfunction

  task automatic add_item(action_t a, code_t c);
    key_jobs.push_back('{is_cfg: 1'b0, act: a, code: c});
  endtask

  task automatic add_cfg(code_t v);
    key_jobs.push_back('{is_cfg: 1'b1, act: ACT_PUSH, code: v});
  endtask

  task automatic add_random_phase(code_t tog, int count);
    code_t cons [16];
    code_t vows [5];
    int    n;
    int    pop_pct;
    int    r;
    cons = '{CH_K, CH_S, CH_T, CH_N, CH_H, CH_M, CH_Y, CH_R,
             CH_W, CH_G, CH_Z, CH_D, CH_B, CH_P, CH_J, CH_F};
    vows = '{CH_A, CH_I, CH_U, CH_E, CH_O};
    n = 0;
    pop_pct = 40;
    while (n < count) begin
      if ($urandom_range(39) == 0) begin
        case ($urandom_range(3))
          0: pop_pct = 5;
          1: pop_pct = 30;
          2: pop_pct = 50;
          default: pop_pct = 80;
        endcase
      end
      if ($urandom_range(99) < pop_pct) begin
        add_item(ACT_POP, code_t'($urandom));
        n++;
      end else begin
        r = $urandom_range(99);
        if (r < 40) begin
          add_item(ACT_PUSH, cons[$urandom_range(15)]);
          add_item(ACT_PUSH, vows[$urandom_range(4)]);
          n += 2;
        end else if (r < 52) begin
          add_item(ACT_PUSH, vows[$urandom_range(4)]);
          n++;
        end else if (r < 58) begin
          add_item(ACT_PUSH, tog);
          n++;
        end else if (r < 62) begin
          add_item(ACT_PUSH, CH_N);
          add_item(ACT_PUSH, CH_N);
          n += 2;
        end else if (r < 75) begin
          add_item(ACT_PUSH, CH_A + code_t'($urandom_range(25)));
          n++;
        end else if (r < 80) begin
          add_item(ACT_PUSH, cons[$urandom_range(15)]);
          add_item(ACT_PUSH, code_t'($urandom));
          n += 2;
        end else begin
          add_item(ACT_PUSH, code_t'($urandom));
          n++;
        end
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic next_in;
    logic next_cfg;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      calm      <= 1'b0;
      tx_gap = 0;
      settle = 0;
    end else begin
      calm <= (key_jobs.size() < CALM_JOBS);
      if ($urandom_range(149) == 0) begin
        case ($urandom_range(3))
          0: tx_odds = 0;
          1: tx_odds = 3;
          2: tx_odds = 6;
          default: tx_odds = 12;
        endcase
      end
      if (drained && !in_valid && !cfg_valid) begin
        settle++;
      end else begin
        settle = 0;
      end
      if (tx_gap != 0) begin
        tx_gap--;
      end
      if (!(in_valid && !in_ready) && !(cfg_valid && !cfg_ready)) begin
        next_in  = 1'b0;
        next_cfg = 1'b0;
        if (key_jobs.size() != 0 && tx_gap == 0) begin
          if (key_jobs[0].is_cfg) begin
            if (settle >= SETTLE_CYCLES) begin
              next_cfg = 1'b1;
              cfg_data <= key_jobs[0].code;
              void'(key_jobs.pop_front());
              settle = 0;
            end
          end else if (!calm && !hold_off && tx_odds != 0 &&
                       $urandom_range(tx_odds - 1) == 0) begin
            tx_gap = $urandom_range(1, 18);
          end else begin
            next_in = 1'b1;
            action_d <= key_jobs[0].act;
            key_code <= key_jobs[0].code;
            void'(key_jobs.pop_front());
          end
        end
        in_valid  <= next_in;
        cfg_valid <= next_cfg;
      end
    end
  end

  // monitor and result checker
  always @(posedge clk) begin
    key_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      drained   <= 1'b1;
      toggle_m = '0;
      kana_m   = 1'b0;
      pend_m   = '0;
      rd_m     = '0;
      wr_m     = '0;
      rx_gap   = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (kana_results.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected result: valid %0b key %0d kana %0b",
                     key_valid, key_out, kana_on);
          end
          errors++;
        end else begin
          want = kana_results.pop_front();
          if (want.key_valid !== key_valid || want.key_out !== key_out ||
              want.kana_on !== kana_on) begin
            if (errors < 10) begin
              $display("mismatch on result %0d: expected valid %0b key %0d kana %0b,",
                       results_seen, want.key_valid, want.key_out, want.kana_on,
                       " got valid %0b key %0d kana %0b",
                       key_valid, key_out, kana_on);
            end
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        toggle_m = cfg_data;
      end
      if (in_valid && in_ready) begin
        kana_results.push_back(apply_keystroke(action_d, key_code));
      end
      drained <= (kana_results.size() == 0);
      if ($urandom_range(149) == 0) begin
        case ($urandom_range(3))
          0: rx_odds = 0;
          1: rx_odds = 3;
          2: rx_odds = 6;
          default: rx_odds = 12;
        endcase
      end
      if (rx_gap != 0) begin
        rx_gap--;
      end else if (!calm && rx_odds != 0 && $urandom_range(rx_odds - 1) == 0) begin
        rx_gap = $urandom_range(1, 18);
      end
      out_ready <= !hold_off && rx_gap == 0;
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_off  <= 1'b0;
      hold_done <= 1'b0;
      hold_left <= 0;
    end else if (!hold_done && results_seen == 400) begin
      hold_off  <= 1'b1;
      hold_done <= 1'b1;
      hold_left <= 120;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_left <= 0;
      hold_off  <= 1'b0;
    end
  end

  initial begin
    code_t tog;
    tog = 8'h7E;
    add_cfg(tog);
    add_item(ACT_POP, 8'h00);
    add_item(ACT_PUSH, 8'h00);
    add_item(ACT_PUSH, 8'hFF);
    add_item(ACT_POP, 8'hFF);
    add_item(ACT_POP, 8'h00);
    add_item(ACT_PUSH, tog);
    add_item(ACT_PUSH, 8'h00);
    add_item(ACT_PUSH, CH_A);
    add_item(ACT_PUSH, CH_I);
    add_item(ACT_PUSH, CH_U);
    add_item(ACT_PUSH, CH_E);
    add_item(ACT_PUSH, CH_O);
    add_item(ACT_PUSH, CH_K);
    add_item(ACT_PUSH, CH_A);
    add_item(ACT_PUSH, CH_J);
    add_item(ACT_PUSH, CH_I);
    add_item(ACT_PUSH, CH_F);
    add_item(ACT_PUSH, CH_U);
    add_item(ACT_PUSH, CH_Y);
    add_item(ACT_PUSH, CH_E);
    add_item(ACT_PUSH, CH_W);
    add_item(ACT_PUSH, CH_O);
    add_item(ACT_PUSH, CH_N);
    add_item(ACT_PUSH, CH_N);
    add_item(ACT_PUSH, CH_P);
    add_item(ACT_PUSH, 8'h31);
    add_item(ACT_PUSH, CH_S);
    add_item(ACT_PUSH, tog);
    add_item(ACT_POP, 8'h00);
    add_cfg(8'h00);
    add_random_phase(8'h00, PHASE_ITEMS);
    add_cfg(8'hFF);
    add_random_phase(8'hFF, PHASE_ITEMS);
    tog = code_t'($urandom_range(255));
    add_cfg(tog);
    add_random_phase(tog, PHASE_ITEMS);
    add_cfg(CH_K);
    add_random_phase(CH_K, PHASE_ITEMS);
    add_cfg(8'h7E);
    add_random_phase(8'h7E, PHASE_ITEMS);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do begin
      @(posedge clk);
    end while (key_jobs.size() != 0 || in_valid || cfg_valid || !drained);
    repeat (8) @(posedge clk);
    if (kana_results.size() != 0) begin
      $display("%0d results never arrived", kana_results.size());
    end
    if (errors == 0 && kana_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
